// ----- rtl/nnks_pkg.sv -----
// Package: sizes, payload structs and state codes of the top-k neighbour search.
`default_nettype none
package nnks_pkg;
  localparam int MAX_ENTRIES  = 1024;
  localparam int VECTOR_DIM   = 64;
  localparam int MAX_MATCHES  = 16;
  localparam int ELEMENT_BITS = 16;

  localparam int EW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int DW = $clog2(VECTOR_DIM);
  localparam int PW = $clog2(VECTOR_DIM + 1);
  localparam int MW = $clog2(MAX_MATCHES);
  localparam int FW = $clog2(MAX_MATCHES + 1);
  localparam int AW = EW + DW;
  localparam int DISTW = 38;
  localparam logic [DISTW-1:0] DIST_MAX = '1;
  localparam int SQ_LIMIT_BITS = 19;

  localparam logic [1:0] OP_CLEAR    = 2'd0;
  localparam logic [1:0] OP_LOAD     = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] item_id;
    logic signed [15:0] element_value;
    logic        vector_last;
    logic [4:0]  query_limit;
  } nnks_in_t;

  typedef struct packed {
    logic [15:0]      result_id;
    logic [DISTW-1:0] result_distance;
    logic [3:0]       result_rank;
    logic             result_last;
    logic             no_match;
  } nnks_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FILL, ST_IDREAD, ST_DIST, ST_ACC, ST_INSERT, ST_EMIT, ST_NOMATCH
  } nnks_state_t;

  // Saturating square of an element difference.
  function automatic logic [DISTW-1:0] sat_sq(input logic signed [ELEMENT_BITS:0] d);
    logic [ELEMENT_BITS:0] a;
    logic [2*ELEMENT_BITS+1:0] p;
    a = d[ELEMENT_BITS] ? (~d + 1'b1) : d;
    p = a * a;
    if ({{DISTW{1'b0}}, p} > {{(2*ELEMENT_BITS+2){1'b0}}, DIST_MAX}) sat_sq = DIST_MAX;
    else sat_sq = DISTW'(p);
  endfunction
endpackage
`default_nettype wire

// ----- rtl/nnks_ram.sv -----
// Generic single-port-write, single-read synchronous RAM with registered read.
`default_nettype none
module nnks_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/nnks_topk.sv -----
// Sorted list of the best matches, one insertion per request.
`default_nettype none
module nnks_topk import nnks_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             clr,
  input  wire logic             ins,
  input  wire logic [DISTW:0]   ins_dist,
  input  wire logic [15:0]      ins_id,
  input  wire logic [FW-1:0]    lim,
  input  wire logic [MW-1:0]    rd_idx,
  output logic      [DISTW:0]   rd_dist,
  output logic      [15:0]      rd_id,
  output logic      [FW-1:0]    found
);
  logic [DISTW:0] dist_r [MAX_MATCHES];
  logic [15:0]    id_r   [MAX_MATCHES];
  logic [FW-1:0]  found_r, found_nxt;
  logic [MAX_MATCHES-1:0] worse;

  // An entry ranks after the new one when it is farther, or equal with a larger id.
  always_comb begin
    for (int k = 0; k < MAX_MATCHES; k++)
      worse[k] = (FW'(k) >= found_r) || (ins_dist < dist_r[k]) ||
                 (ins_dist == dist_r[k] && ins_id < id_r[k]);
    found_nxt = found_r;
    if (ins && found_r < lim && !(worse == '0)) found_nxt = found_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      found_r <= '0;
    end else begin
      found_r <= found_nxt;
    end
    if (ins) begin
      for (int k = 0; k < MAX_MATCHES; k++) begin
        if (FW'(k) < lim && worse[k]) begin
          if (k == 0 || worse[(k == 0) ? 0 : k-1]) begin
            if (k != 0) begin
              dist_r[k] <= dist_r[(k == 0) ? 0 : k-1];
              id_r[k]   <= id_r[(k == 0) ? 0 : k-1];
            end
          end
          if (k == 0 || !worse[(k == 0) ? 0 : k-1]) begin
            dist_r[k] <= ins_dist;
            id_r[k]   <= ins_id;
          end
        end
      end
    end
  end

  assign rd_dist = dist_r[rd_idx];
  assign rd_id   = id_r[rd_idx];
  assign found   = found_r;
endmodule
`default_nettype wire

// ----- rtl/nearest_neighbour_topk_search.sv -----
// Top level: vector table in memory, query buffer, distance scan and result emission.
//   channel | direction | signals
//   in      | in        | start, busy, in_item (nnks_in_t)
//   out     | out       | out_valid, out_result (nnks_out_t)
// Clear and element requests are accepted one per cycle while busy is low. A last element that
// ends a vector before position VECTOR_DIM-1 then keeps busy high while the unused positions
// are written with zeros; a dropped load skips this.
// A last query element then scans every stored entry and emits one result per cycle; an
// invalid query gives its single no_match result after the fill, if any, without a scan.
// Reset is synchronous, active low, and empties the table. Results cannot be stalled.
`default_nettype none
module nearest_neighbour_topk_search import nnks_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire nnks_in_t  in_item,
  output logic           out_valid,
  output nnks_out_t      out_result
);
  nnks_state_t state_r, state_nxt;
  logic [CW-1:0] count_r;
  logic [PW-1:0] pos_r;
  logic [EW-1:0] ent_r;
  logic [DW-1:0] el_r;
  logic [DISTW-1:0] sum_r;
  logic [15:0] qid_r, eid_r;
  logic [FW-1:0] lim_r;
  logic [MW-1:0] emit_r;
  logic rd_v_r;
  logic accept;
  logic [DW-1:0] fill_pos_r;
  logic [EW-1:0] fill_slot_r;
  logic fill_qry_r, scan_ok_r;
  logic filling;

  assign accept = start && !busy;
  assign busy = (state_r != ST_IDLE);
  assign filling = (state_r == ST_FILL);

  wire is_elem = accept && (in_item.opcode == OP_LOAD || in_item.opcode == OP_QUERY);
  wire in_vec  = pos_r < PW'(VECTOR_DIM);
  wire load_ok = count_r < CW'(MAX_ENTRIES);
  wire load_wr = is_elem && in_item.opcode == OP_LOAD && load_ok;
  wire qry_wr  = is_elem && in_item.opcode == OP_QUERY;
  wire query_end = qry_wr && in_item.vector_last;
  wire scan_ok = in_item.item_id != 16'd0 && in_item.query_limit != 5'd0 && count_r != '0;
  // A vector that ends early has its remaining positions written with zeros, one per cycle.
  wire fill_start = in_item.vector_last && pos_r < PW'(VECTOR_DIM-1) && (load_wr || qry_wr);

  // Entry vectors.
  logic [AW-1:0] v_raddr, v_waddr;
  logic [ELEMENT_BITS-1:0] v_rdata, q_rdata;
  assign v_waddr = filling ? {fill_slot_r, fill_pos_r} : {count_r[EW-1:0], pos_r[DW-1:0]};
  nnks_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(MAX_ENTRIES*VECTOR_DIM)) u_vec (
    .clk, .we((load_wr && in_vec) || (filling && !fill_qry_r)),
    .waddr(v_waddr),
    .wdata(filling ? '0 : in_item.element_value[ELEMENT_BITS-1:0]),
    .raddr(v_raddr), .rdata(v_rdata));
  nnks_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(VECTOR_DIM)) u_qry (
    .clk, .we((qry_wr && in_vec) || (filling && fill_qry_r)),
    .waddr(filling ? fill_pos_r : pos_r[DW-1:0]),
    .wdata(filling ? '0 : in_item.element_value[ELEMENT_BITS-1:0]),
    .raddr(el_r), .rdata(q_rdata));
  // Entry id of each stored entry.
  logic [15:0] meta_rdata;
  nnks_ram #(.WIDTH(16), .DEPTH(MAX_ENTRIES)) u_meta (
    .clk, .we(load_wr && in_item.vector_last),
    .waddr(count_r[EW-1:0]),
    .wdata(in_item.item_id),
    .raddr(ent_r), .rdata(meta_rdata));
  assign v_raddr = {ent_r, el_r};

  logic signed [ELEMENT_BITS:0] diff;
  logic [DISTW-1:0] sq_r;
  logic sq_v_r;
  assign diff = $signed({q_rdata[ELEMENT_BITS-1], q_rdata}) -
                $signed({v_rdata[ELEMENT_BITS-1], v_rdata});
  wire [DISTW:0] add = {1'b0, sum_r} + {1'b0, sq_r};

  logic tk_clr, tk_ins;
  logic [DISTW:0] tk_dist;
  logic [15:0] tk_id;
  logic [FW-1:0] found;
  nnks_topk u_topk (.clk, .rst_n, .clr(tk_clr), .ins(tk_ins),
    .ins_dist({1'b0, sum_r}), .ins_id(eid_r), .lim(lim_r), .rd_idx(emit_r),
    .rd_dist(tk_dist), .rd_id(tk_id), .found(found));

  wire last_el = (el_r == DW'(VECTOR_DIM-1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (fill_start) state_nxt = ST_FILL;
        else if (query_end) state_nxt = scan_ok ? ST_IDREAD : ST_NOMATCH;
      end
      ST_FILL: begin
        if (fill_pos_r == DW'(VECTOR_DIM-1))
          state_nxt = !fill_qry_r ? ST_IDLE : (scan_ok_r ? ST_IDREAD : ST_NOMATCH);
      end
      ST_IDREAD:  state_nxt = ST_DIST;
      ST_DIST:    if (last_el) state_nxt = ST_ACC;
      ST_ACC:     if (!sq_v_r && !rd_v_r) state_nxt = ST_INSERT;
      ST_INSERT:  state_nxt = (CW'(ent_r) + 1'b1 == count_r) ?
                    ((found == '0 && eid_r == qid_r) ? ST_NOMATCH : ST_EMIT) : ST_IDREAD;
      ST_EMIT:    if (FW'(emit_r) + 1'b1 == found) state_nxt = ST_IDLE;
      ST_NOMATCH: state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    tk_clr = query_end;
    tk_ins = (state_r == ST_INSERT) && (eid_r != qid_r);
    out_valid = (state_r == ST_EMIT) || (state_r == ST_NOMATCH);
    out_result = '0;
    if (state_r == ST_NOMATCH) begin
      out_result.no_match = 1'b1;
      out_result.result_last = 1'b1;
    end else if (state_r == ST_EMIT) begin
      out_result.result_id = tk_id;
      out_result.result_distance = tk_dist[DISTW-1:0];
      out_result.result_rank = 4'(emit_r);
      out_result.result_last = (FW'(emit_r) + 1'b1 == found);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; count_r <= '0; pos_r <= '0;
      rd_v_r <= 1'b0; sq_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && in_item.opcode == OP_CLEAR) begin
        count_r <= '0; pos_r <= '0;
      end else if (is_elem) begin
        if (in_item.vector_last) pos_r <= '0;
        else if (in_vec) pos_r <= pos_r + 1'b1;
        if (in_item.opcode == OP_LOAD && in_item.vector_last && load_ok)
          count_r <= count_r + 1'b1;
      end
      rd_v_r <= (state_r == ST_DIST);
      sq_v_r <= rd_v_r;
    end
    if (query_end) begin
      qid_r <= in_item.item_id;
      lim_r <= (in_item.query_limit > 5'(MAX_MATCHES)) ? FW'(MAX_MATCHES)
                                                         : FW'(in_item.query_limit);
      scan_ok_r <= scan_ok;
      ent_r <= '0;
      emit_r <= '0;
    end
    if (fill_start) begin
      fill_pos_r <= pos_r[DW-1:0] + 1'b1;
      fill_slot_r <= count_r[EW-1:0];
      fill_qry_r <= qry_wr;
    end
    case (state_r)
      ST_FILL: fill_pos_r <= fill_pos_r + 1'b1;
      ST_IDREAD: begin el_r <= '0; sum_r <= '0; end
      ST_DIST: begin
        if (el_r == DW'(0)) eid_r <= meta_rdata;
        if (!last_el) el_r <= el_r + 1'b1;
      end
      ST_INSERT: ent_r <= ent_r + 1'b1;
      ST_EMIT: emit_r <= emit_r + 1'b1;
      default: ;
    endcase
    sq_r <= sat_sq(diff);
    if (sq_v_r) sum_r <= add[DISTW] ? DIST_MAX : add[DISTW-1:0];
  end

`ifndef SYNTHESIS
  a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !out_valid) else $error("result outside a query");
  a_nomatch_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.no_match) |-> out_result.result_last) else $error("bad no_match");
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES)) else $error("entry count overflow");
`endif
endmodule
`default_nettype wire
